// File: hdl/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// lrukv_pkg: shared types and constants of the LRU key/value cache
// Request and response payloads, op codes, engine states, register reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrukv_pkg;

   localparam int DATA_W = 32;
   localparam int CSR_W  = 5;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   localparam logic [CSR_W-1:0]         CAP_RESET  = 5'd16;
   localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

   typedef struct packed {
      logic                     op;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_RESULT
   } engine_state_type;

endpackage

`default_nettype wire

// File: hdl/lru_cache_key_value_core.sv
// ----------------------------------------------------------------------------
// lru_cache_key_value_core: fully associative LRU key/value cache
// One request at a time; scan and rank update passes walk one entry per cycle.
// Put: next request accepted once the rank update pass ends. Get: response
// valid after the update pass on a hit, after the scan pass on a miss; next
// request once the response loads, later while a full response is stalled.
// Reset is synchronous: all entries invalid, occupancy 0, capacity 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_cache_key_value_core
   import lrukv_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_payload_type  req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_payload_type  rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data
);

   logic [CSR_W-1:0] capacity_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff;

   logic             eng_idle;
   logic             eng_res_valid;
   rsp_payload_type  eng_res;
   logic             start;
   logic             res_take;

   assign csr_ready = 1'b1;
   assign req_stall = !eng_idle;
   assign start     = req_valid && !req_stall;
   // load the output register when it is empty or draining this cycle
   assign res_take  = eng_res_valid && (!rsp_valid_ff || !rsp_stall);

   lrukv_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .cap       (capacity_ff),
      .res_take  (res_take),
      .idle      (eng_idle),
      .res_valid (eng_res_valid),
      .res       (eng_res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= eng_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("engine took a request but did not go busy");

   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      eng_res_valid |-> req_stall)
      else $error("request accepted while a result is pending");

   a_rsp_from_engine: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(eng_res_valid))
      else $error("response appeared without an engine result");

endmodule

`default_nettype wire

// File: hdl/lrukv_engine.sv
// ----------------------------------------------------------------------------
// lrukv_engine: lookup and recency engine of the LRU key/value cache
// Key/value and rank memories, one entry per cycle: a scan pass finds the
// hit, the first free slot and the oldest entry; an update pass rewrites ranks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrukv_engine
   import lrukv_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  req_payload_type  req,
   input  logic [CSR_W-1:0] cap,
   input  logic             res_take,
   output logic             idle,
   output logic             res_valid,
   output rsp_payload_type  res
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = IDX_W + 1;
   localparam int OCC_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (OCC_W > CSR_W) ? OCC_W : CSR_W;
   localparam int KV_W   = 2 * DATA_W;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CAPACITY);
   localparam logic [OCC_W-1:0] OCC_CAP  = OCC_W'(CAPACITY);
   localparam logic [CMP_W-1:0] CMP_CAP  = CMP_W'(CAPACITY);

   // memories
   logic [KV_W-1:0]   kv_mem_ff   [CAPACITY];
   logic [RANK_W-1:0] rank_mem_ff [CAPACITY];
   logic [KV_W-1:0]   kv_rd_ff;
   logic [RANK_W-1:0] rank_rd_ff;

   logic              issue;
   logic [IDX_W-1:0]  rd_addr;
   logic              kv_we;
   logic [IDX_W-1:0]  kv_wa;
   logic [KV_W-1:0]   kv_wd;
   logic              rank_we;
   logic [IDX_W-1:0]  rank_wa;
   logic [RANK_W-1:0] rank_wd;

   engine_state_type  state_ff, state_in;
   req_payload_type   req_ff, req_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]  pipe_idx_ff, pipe_idx_in;

   logic                     hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]         hit_slot_ff, hit_slot_in;
   logic [RANK_W-1:0]        hit_rank_ff, hit_rank_in;
   logic signed [DATA_W-1:0] hit_value_ff, hit_value_in;
   logic                     free_found_ff, free_found_in;
   logic [IDX_W-1:0]         free_slot_ff, free_slot_in;
   logic                     old_found_ff, old_found_in;
   logic [IDX_W-1:0]         old_slot_ff, old_slot_in;
   logic [RANK_W-1:0]        old_rank_ff, old_rank_in;

   logic [IDX_W-1:0]    tgt_ff, tgt_in;
   logic [RANK_W-1:0]   thr_ff, thr_in;
   logic                inc_all_ff, inc_all_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;
   rsp_payload_type     res_ff, res_in;

   logic [CMP_W-1:0]  cap_wide;
   logic [OCC_W-1:0]  eff_cap;
   logic              entry_valid;
   logic [DATA_W-1:0] rd_key;

   // clamp the capacity register to 1 .. CAPACITY
   always_comb begin
      cap_wide = CMP_W'(cap);
      if (cap == '0) begin
         eff_cap = OCC_W'(1);
      end else if (cap_wide > CMP_CAP) begin
         eff_cap = OCC_CAP;
      end else begin
         eff_cap = cap_wide[OCC_W-1:0];
      end
   end

   assign issue       = ((state_ff == ST_SCAN) || (state_ff == ST_UPDATE)) &&
                        (cnt_ff != CNT_END);
   assign rd_addr     = cnt_ff[IDX_W-1:0];
   assign entry_valid = valid_ff[pipe_idx_ff];
   assign rd_key      = kv_rd_ff[KV_W-1:DATA_W];

   always_ff @(posedge clock) begin
      if (kv_we) begin
         kv_mem_ff[kv_wa] <= kv_wd;
      end
      if (rank_we) begin
         rank_mem_ff[rank_wa] <= rank_wd;
      end
      if (issue) begin
         kv_rd_ff   <= kv_mem_ff[rd_addr];
         rank_rd_ff <= rank_mem_ff[rd_addr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      cnt_in        = issue ? cnt_ff + CNT_W'(1) : cnt_ff;
      pipe_vld_in   = issue;
      pipe_idx_in   = rd_addr;
      hit_found_in  = hit_found_ff;
      hit_slot_in   = hit_slot_ff;
      hit_rank_in   = hit_rank_ff;
      hit_value_in  = hit_value_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      old_found_in  = old_found_ff;
      old_slot_in   = old_slot_ff;
      old_rank_in   = old_rank_ff;
      tgt_in        = tgt_ff;
      thr_in        = thr_ff;
      inc_all_in    = inc_all_ff;
      valid_in      = valid_ff;
      occ_in        = occ_ff;
      res_in        = res_ff;
      kv_we         = 1'b0;
      kv_wa         = hit_slot_ff;
      kv_wd         = {req_ff.key, req_ff.value};
      rank_we       = 1'b0;
      rank_wa       = pipe_idx_ff;
      rank_wd       = '0;
      res_valid     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in        = req;
               cnt_in        = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               old_found_in  = 1'b0;
               state_in      = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (pipe_vld_ff) begin
               if (entry_valid && !hit_found_ff && (rd_key == req_ff.key)) begin
                  hit_found_in = 1'b1;
                  hit_slot_in  = pipe_idx_ff;
                  hit_rank_in  = rank_rd_ff;
                  hit_value_in = kv_rd_ff[DATA_W-1:0];
               end
               if (!entry_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = pipe_idx_ff;
               end
               if (entry_valid && (!old_found_ff || (rank_rd_ff > old_rank_ff))) begin
                  old_found_in = 1'b1;
                  old_slot_in  = pipe_idx_ff;
                  old_rank_in  = rank_rd_ff;
               end
               if (pipe_idx_ff == LAST_IDX) begin
                  state_in = ST_DECIDE;
               end
            end
         end

         ST_DECIDE: begin
            cnt_in     = '0;
            inc_all_in = 1'b0;
            if (hit_found_ff) begin
               tgt_in   = hit_slot_ff;
               thr_in   = hit_rank_ff;
               kv_we    = (req_ff.op == OP_PUT);
               kv_wa    = hit_slot_ff;
               res_in   = '{hit: 1'b1, read_value: hit_value_ff};
               state_in = ST_UPDATE;
            end else if (req_ff.op == OP_GET) begin
               res_in   = '{hit: 1'b0, read_value: MISS_VALUE};
               state_in = ST_RESULT;
            end else if (occ_ff < eff_cap) begin
               // room left: everyone ages, new entry goes in the first free slot
               tgt_in                 = free_slot_ff;
               inc_all_in             = 1'b1;
               valid_in[free_slot_ff] = 1'b1;
               occ_in                 = occ_ff + OCC_W'(1);
               kv_we                  = 1'b1;
               kv_wa                  = free_slot_ff;
               state_in               = ST_UPDATE;
            end else begin
               // evict the oldest entry and reuse its slot
               tgt_in   = old_slot_ff;
               thr_in   = old_rank_ff;
               kv_we    = 1'b1;
               kv_wa    = old_slot_ff;
               state_in = ST_UPDATE;
            end
         end

         ST_UPDATE: begin
            if (pipe_vld_ff) begin
               if (pipe_idx_ff == tgt_ff) begin
                  rank_we = 1'b1;
                  rank_wd = '0;
               end else if (entry_valid && (inc_all_ff || (rank_rd_ff < thr_ff))) begin
                  rank_we = 1'b1;
                  rank_wd = rank_rd_ff + RANK_W'(1);
               end
               if (pipe_idx_ff == LAST_IDX) begin
                  state_in = (req_ff.op == OP_GET) ? ST_RESULT : ST_IDLE;
               end
            end
         end

         ST_RESULT: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pipe_vld_ff <= 1'b0;
         valid_ff    <= '0;
         occ_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         pipe_vld_ff <= pipe_vld_in;
         valid_ff    <= valid_in;
         occ_ff      <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      cnt_ff        <= cnt_in;
      pipe_idx_ff   <= pipe_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_slot_ff   <= hit_slot_in;
      hit_rank_ff   <= hit_rank_in;
      hit_value_ff  <= hit_value_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      old_found_ff  <= old_found_in;
      old_slot_ff   <= old_slot_in;
      old_rank_ff   <= old_rank_in;
      tgt_ff        <= tgt_in;
      thr_ff        <= thr_in;
      inc_all_ff    <= inc_all_in;
      res_ff        <= res_in;
   end

   assign idle = (state_ff == ST_IDLE);
   assign res  = res_ff;

endmodule

`default_nettype wire

// File: sim/lru_cache_key_value_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_key_value_core_tb: self-checking bench for the LRU key/value cache
// Directed gets and puts over key and value extremes, then random phases
// under several capacity settings with random idle and stall bursts. A
// shadow cache predicts each get result, and the monitor checks every field.
// ----------------------------------------------------------------------------

module lru_cache_key_value_core_tb;
   import lrukv_pkg::*;

   localparam int CAPACITY     = 16;
   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 10;
   localparam int DRAIN_CYCLES = 60;
   localparam int LONG_HOLD    = 400;
   localparam int PHASE_ITEMS  = 160;
   localparam int NUM_PHASES   = 9;
   localparam int LIMIT_CYCLES = 400000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_payload_type  req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_payload_type  rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_data  = '0;

   lru_cache_key_value_core #(
      .CAPACITY (CAPACITY)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Shadow copy of the cache contents and of the capacity register
   logic              slot_live [CAPACITY];
   logic [DATA_W-1:0] slot_key  [CAPACITY];
   logic [DATA_W-1:0] slot_val  [CAPACITY];
   int unsigned       slot_age  [CAPACITY];
   int unsigned       live_count;
   logic [CSR_W-1:0]  cap_setting;

   req_payload_type   pending_requests [$];
   rsp_payload_type   awaited_lookups [$];
   logic [DATA_W-1:0] key_pool [$];
   logic [CSR_W-1:0]  phase_caps [NUM_PHASES];

   int          accepted_count = 0;
   int          mismatch_count = 0;
   int          idle_pct       = 0;
   int          stall_pct      = 0;
   bit          sender_pause   = 1'b0;
   int          gap_left       = 0;
   int          hold_ticket    = 0;
   int          hold_seen      = 0;
   int          hold_left      = 0;
   int          stall_left     = 0;
   int unsigned cycle_count    = 0;

   function automatic int unsigned effective_capacity();
      if (cap_setting == 0)
         return 1;
      if (cap_setting > CAPACITY)
         return CAPACITY;
      return cap_setting;
   endfunction

   function automatic int find_slot_of(logic [DATA_W-1:0] k);
      for (int i = 0; i < CAPACITY; i++)
         if (slot_live[i] && slot_key[i] == k)
            return i;
      return -1;
   endfunction

   function automatic void make_newest(int s);
      int unsigned r;
      r = slot_age[s];
      for (int i = 0; i < CAPACITY; i++)
         if (slot_live[i] && slot_age[i] < r)
            slot_age[i]++;
      slot_age[s] = 0;
   endfunction

   function automatic void store_new_key(logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
      int s;
      s = -1;
      if (live_count < effective_capacity()) begin
         for (int i = CAPACITY - 1; i >= 0; i--)
            if (!slot_live[i])
               s = i;
      end
      if (s >= 0) begin
         for (int i = 0; i < CAPACITY; i++)
            if (slot_live[i])
               slot_age[i]++;
         slot_live[s] = 1'b1;
         slot_age[s]  = 0;
         live_count++;
      end else begin
         // reuse the least recent slot, lowest index on a tie
         for (int i = 0; i < CAPACITY; i++)
            if (slot_live[i] && (s < 0 || slot_age[i] > slot_age[s]))
               s = i;
         if (s < 0)
            return;
         make_newest(s);
      end
      slot_key[s] = k;
      slot_val[s] = v;
   endfunction

   // Update the shadow cache; return 1 when the request yields a lookup result
   function automatic bit apply_cache_request(req_payload_type r, output rsp_payload_type res);
      int s;
      s   = find_slot_of(r.key);
      res = '0;
      if (r.op == OP_PUT) begin
         if (s >= 0) begin
            slot_val[s] = r.value;
            make_newest(s);
         end else begin
            store_new_key(r.key, r.value);
         end
         return 1'b0;
      end
      if (s >= 0) begin
         make_newest(s);
         res.hit        = 1'b1;
         res.read_value = slot_val[s];
      end else begin
         res.hit        = 1'b0;
         res.read_value = MISS_VALUE;
      end
      return 1'b1;
   endfunction

   function automatic req_payload_type req_of(logic op, logic [DATA_W-1:0] k,
                                              logic [DATA_W-1:0] v);
      req_payload_type r;
      r.op    = op;
      r.key   = k;
      r.value = v;
      return r;
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type r;
      r.op    = ($urandom_range(99) < 55) ? OP_PUT : OP_GET;
      r.key   = ($urandom_range(9) == 0) ? $urandom
                                         : key_pool[$urandom_range(key_pool.size() - 1)];
      r.value = $urandom;
      return r;
   endfunction

   // Request driver
   always @(posedge clock) begin
      rsp_payload_type predicted;
      logic            next_valid;
      req_payload_type next_data;
      next_valid = req_valid;
      next_data  = req_data;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (apply_cache_request(req_data, predicted))
               awaited_lookups.push_back(predicted);
            accepted_count++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() != 0 && !sender_pause) begin
               if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                  gap_left = $urandom_range(8);
               end else begin
                  next_data  = pending_requests.pop_front();
                  next_valid = 1'b1;
               end
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_data;
   end

   // Result monitor and response stall
   always @(posedge clock) begin
      rsp_payload_type want;
      logic            next_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_lookups.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected lookup result: hit %0b read_value %0d",
                        rsp_data.hit, rsp_data.read_value);
         end else begin
            want = awaited_lookups.pop_front();
            if (rsp_data.hit !== want.hit || rsp_data.read_value !== want.read_value) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("lookup mismatch: hit exp %0b got %0b, read_value exp %0d got %0d",
                           want.hit, rsp_data.hit, want.read_value, rsp_data.read_value);
            end
         end
      end
      next_stall = 1'b0;
      if (hold_left > 0) begin
         hold_left--;
         next_stall = 1'b1;
      end else if (hold_ticket != hold_seen) begin
         hold_seen  = hold_ticket;
         hold_left  = LONG_HOLD - 1;
         next_stall = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         next_stall = 1'b1;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
         stall_left = $urandom_range(8);
         next_stall = 1'b1;
      end
      rsp_stall <= next_stall;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic write_capacity(logic [CSR_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      cap_setting = v;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Wait for every request to drain, then let a trailing put finish
   task automatic wait_until_quiet();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || awaited_lookups.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int target;
      phase_caps = '{5'd3, 5'd0, 5'd16, 5'd7, 5'd31, 5'd1, 5'd12, 5'd2, 5'd16};
      cap_setting = CAP_RESET;
      live_count  = 0;
      foreach (slot_live[i]) begin
         slot_live[i] = 1'b0;
         slot_key[i]  = '0;
         slot_val[i]  = '0;
         slot_age[i]  = 0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // above the physical size: acts as full capacity
      write_capacity(5'd31);
      idle_pct  = 20;
      stall_pct = 20;
      pending_requests.push_back(req_of(OP_GET, 32'h0000_0000, 32'h0000_0000));
      pending_requests.push_back(req_of(OP_PUT, 32'h8000_0000, 32'h7fff_ffff));
      pending_requests.push_back(req_of(OP_PUT, 32'h7fff_ffff, 32'h8000_0000));
      pending_requests.push_back(req_of(OP_PUT, 32'h0000_0000, 32'hffff_ffff));
      pending_requests.push_back(req_of(OP_PUT, 32'hffff_ffff, 32'h0000_0000));
      pending_requests.push_back(req_of(OP_GET, 32'h8000_0000, 32'hffff_ffff));
      // touch the most recent entry again
      pending_requests.push_back(req_of(OP_GET, 32'h8000_0000, 32'h0000_0000));
      pending_requests.push_back(req_of(OP_GET, 32'h7fff_ffff, 32'h0000_0000));
      pending_requests.push_back(req_of(OP_PUT, 32'h0000_0000, 32'h5a5a_a5a5));
      pending_requests.push_back(req_of(OP_GET, 32'h0000_0000, 32'h0000_0000));
      pending_requests.push_back(req_of(OP_GET, 32'h0000_0005, 32'h0000_0000));
      // fill the store, the last put evicts key -1
      for (int k = 1; k <= 13; k++)
         pending_requests.push_back(req_of(OP_PUT, 32'h0000_1000 + k, $urandom));
      pending_requests.push_back(req_of(OP_GET, 32'hffff_ffff, 32'h0000_0000));
      wait_until_quiet();

      // first phase lowers the capacity below a full store
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_capacity(phase_caps[p]);
         if (p == NUM_PHASES - 1) begin
            idle_pct  = 0;
            stall_pct = 0;
         end else begin
            idle_pct  = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
         end
         key_pool.delete();
         repeat (effective_capacity() + $urandom_range(1, 6))
            key_pool.push_back($urandom);
         if ($urandom_range(1) == 1) begin
            key_pool.push_back(32'h8000_0000);
            key_pool.push_back(32'h7fff_ffff);
            key_pool.push_back(32'h0000_0000);
            key_pool.push_back(32'hffff_ffff);
         end
         target = accepted_count + PHASE_ITEMS / 2;
         for (int n = 0; n < PHASE_ITEMS; n++)
            pending_requests.push_back(random_request());
         if (p == 2)
            hold_ticket++;
         if (p == 4) begin
            do @(negedge clock); while (accepted_count < target);
            // hold new requests until every lookup result is back
            sender_pause = 1'b1;
            do @(negedge clock); while (req_valid || awaited_lookups.size() != 0);
            sender_pause = 1'b0;
         end
         wait_until_quiet();
      end

      if (mismatch_count == 0 && awaited_lookups.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: sim.f
hdl/lrukv_pkg.sv
hdl/lrukv_engine.sv
hdl/lru_cache_key_value_core.sv
sim/lru_cache_key_value_core_tb.sv
